// ===== hdl/tsna_pkg.sv =====
//------------------------------------------------------------------------------
// tsna_pkg
// Shared types, opcodes, state codes and the autotile sprite table.
//------------------------------------------------------------------------------
package tsna_pkg;

   localparam int GridWidthDefault  = 64;
   localparam int GridHeightDefault = 64;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] col;
      logic [7:0] row;
      logic [3:0] material;
      logic [7:0] sprite_col;
      logic [7:0] sprite_row;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [3:0] tile_material;
      logic [7:0] tile_sprite_col;
      logic [7:0] tile_sprite_row;
   } rsp_type;

   // one tile as kept in the store
   typedef struct packed {
      logic [3:0] mat;
      logic [7:0] scol;
      logic [7:0] srow;
   } tile_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ_WAIT,
      ST_WRITE,
      ST_CENTER_REQ,
      ST_CENTER_WAIT,
      ST_NBR_REQ,
      ST_NBR_WAIT,
      ST_UPDATE,
      ST_RESPOND
   } state_type;

   // memory request from sequencer to store
   typedef struct packed {
      logic       we;
      logic [15:0] addr;
      tile_type   wdata;
   } mem_req_type;

   // packed as {col, row} per mask value
   function automatic logic [15:0] autotile_lookup(input logic [7:0] mask);
      logic [3:0] c;
      logic [3:0] r;
      c = 4'd0;
      r = 4'd0;
      case (mask[4:0])
         5'd0, 5'd1, 5'd4, 5'd5: begin c = 4'd1; r = 4'd0; end
         5'd2, 5'd3, 5'd6, 5'd7: begin c = 4'd2; r = 4'd4; end
         5'd8, 5'd9, 5'd12, 5'd13: begin c = 4'd3; r = 4'd4; end
         5'd10, 5'd14: begin c = 4'd1; r = 4'd4; end
         5'd11, 5'd15: begin c = 4'd1; r = 4'd2; end
         5'd16, 5'd17, 5'd20, 5'd21: begin c = 4'd2; r = 4'd3; end
         5'd18, 5'd19: begin c = 4'd0; r = 4'd4; end
         5'd22: begin c = 4'd0; r = 4'd2; end
         5'd23: begin c = 4'd0; r = 4'd3; end
         5'd24, 5'd25, 5'd28, 5'd29: begin c = 4'd3; r = 4'd10; end
         5'd26: begin c = 4'd1; r = 4'd7; end
         5'd27: begin c = 4'd0; r = 4'd6; end
         5'd30: begin c = 4'd1; r = 4'd6; end
         5'd31: begin c = 4'd2; r = 4'd2; end
         default: begin c = 4'd0; r = 4'd0; end
      endcase
      return {4'd0, c, 4'd0, r};
   endfunction

   // full table spelled out to keep irregular entries exact
   function automatic logic [15:0] autotile_table(input logic [7:0] mask);
      logic [7:0] c;
      logic [7:0] r;
      logic [63:0] rowc;
      logic [63:0] rowr;
      c = 8'd0;
      r = 8'd0;
      rowc = 64'd0;
      rowr = 64'd0;
      // each group of 8 entries: 8 cols then 8 rows, 4 bits each, entry 0 low
      case (mask[7:3])
         5'd0:  begin rowc = 64'h2211_2211; rowr = 64'h4400_4400; end
         5'd1:  begin rowc = 64'h1133_1133; rowr = 64'h2444_2444; end
         5'd2:  begin rowc = 64'h0022_0022; rowr = 64'h3233_4433; end
         5'd3:  begin rowc = 64'h2133_0133; rowr = 64'h26AA_67AA; end
         5'd4:  begin rowc = 64'h2211_2211; rowr = 64'h4400_4400; end
         5'd5:  begin rowc = 64'h1133_1133; rowr = 64'h2444_2444; end
         5'd6:  begin rowc = 64'h0022_0022; rowr = 64'h3333_4433; end
         5'd7:  begin rowc = 64'h2133_0133; rowr = 64'h26AA_67AA; end
         5'd8:  begin rowc = 64'h3333_3333; rowr = 64'h9933_9933; end
         5'd9:  begin rowc = 64'h3011_3011; rowr = 64'h5733_5733; end
         5'd10: begin rowc = 64'h2200_1100; rowr = 64'h5533_8833; end
         5'd11: begin rowc = 64'h2100_0300; rowr = 64'h8B88_B088; end
         5'd12: begin rowc = 64'h3333_3333; rowr = 64'h9933_9933; end
         5'd13: begin rowc = 64'h3211_3311; rowr = 64'h2911_2611; end
         5'd14: begin rowc = 64'h2200_1100; rowr = 64'h5533_8833; end
         5'd15: begin rowc = 64'h2200_3200; rowr = 64'h8955_8B55; end
         5'd16: begin rowc = 64'h2211_2211; rowr = 64'h4400_4400; end
         5'd17: begin rowc = 64'h1133_1133; rowr = 64'h2444_2444; end
         5'd18: begin rowc = 64'h0022_0022; rowr = 64'h2233_4433; end
         5'd19: begin rowc = 64'h2133_0133; rowr = 64'h26AA_67AA; end
         5'd20: begin rowc = 64'h2211_2211; rowr = 64'h4400_4400; end
         5'd21: begin rowc = 64'h1133_1133; rowr = 64'h2444_2444; end
         5'd22: begin rowc = 64'h0022_0022; rowr = 64'h2233_4433; end
         5'd23: begin rowc = 64'h2133_0133; rowr = 64'h26AA_67AA; end
         5'd24: begin rowc = 64'h3333_3333; rowr = 64'h9933_9933; end
         5'd25: begin rowc = 64'h3011_3011; rowr = 64'h5733_5733; end
         5'd26: begin rowc = 64'h2200_2200; rowr = 64'h1111_6611; end
         5'd27: begin rowc = 64'h1211_2311; rowr = 64'h9755_AB55; end
         5'd28: begin rowc = 64'h3333_3333; rowr = 64'h9933_9933; end
         5'd29: begin rowc = 64'h3311_3311; rowr = 64'h2611_2611; end
         5'd30: begin rowc = 64'h2200_2200; rowr = 64'h1111_6611; end
         5'd31: begin rowc = 64'h2133_0333; rowr = 64'h0A11_A711; end
         default: begin rowc = 64'd0; rowr = 64'd0; end
      endcase
      c = {4'd0, rowc[{mask[2:0], 2'b00} +: 4]};
      r = {4'd0, rowr[{mask[2:0], 2'b00} +: 4]};
      return {c, r};
   endfunction

endpackage

// ===== hdl/tsna_store.sv =====
//------------------------------------------------------------------------------
// tsna_store
// Single-port tile memory with registered read.
//------------------------------------------------------------------------------
module tsna_store #(
   parameter int Depth = tsna_pkg::GridWidthDefault * tsna_pkg::GridHeightDefault,
   parameter int AddrBits = $clog2(Depth)
) (
   input  logic                   clock,
   input  tsna_pkg::mem_req_type  mem_req,
   input  logic                   mem_en,
   output tsna_pkg::tile_type     rdata
);

   tsna_pkg::tile_type mem [Depth];
   tsna_pkg::tile_type rdata_ff;

   // one access per cycle: write or read
   always_ff @(posedge clock) begin
      if (mem_en) begin
         if (mem_req.we) begin
            mem[mem_req.addr[AddrBits-1:0]] <= mem_req.wdata;
         end else begin
            rdata_ff <= mem[mem_req.addr[AddrBits-1:0]];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/tsna_seq.sv =====
//------------------------------------------------------------------------------
// tsna_seq
// Sequencer: decodes items, walks the retile window, sweeps the clear.
//------------------------------------------------------------------------------
module tsna_seq #(
   parameter int GridWidth  = tsna_pkg::GridWidthDefault,
   parameter int GridHeight = tsna_pkg::GridHeightDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tsna_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tsna_pkg::rsp_type     rsp_data,
   input  logic [3:0]            dirt_material,
   output tsna_pkg::mem_req_type mem_req,
   output logic                  mem_en,
   input  tsna_pkg::tile_type    rdata
);

   localparam int Depth = GridWidth * GridHeight;
   localparam int CntBits = $clog2(Depth + 1);

   tsna_pkg::state_type state_ff, state_in;
   tsna_pkg::req_type   req_ff;
   logic [8:0]          ccol_ff, ccol_in;   // current center, a cell of the window
   logic [8:0]          crow_ff, crow_in;
   logic [3:0]          win_ff, win_in;     // window position 0..8
   logic [2:0]          nbr_ff, nbr_in;     // neighbor index
   logic [7:0]          mask_ff, mask_in;
   tsna_pkg::tile_type  ctile_ff, ctile_in;
   logic [CntBits-1:0]  clr_ff, clr_in;
   logic                clr_busy_ff, clr_busy_in;
   logic                init_ff, init_in;   // sweep after reset, no response
   tsna_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                accept;
   logic                in_range;
   logic signed [9:0]   ncol;
   logic signed [9:0]   nrow;
   logic                n_off;
   logic signed [9:0]   wcol;
   logic signed [9:0]   wrow;
   logic                w_off;
   logic [15:0]         lut;

   assign accept = req_valid && !req_stall;
   assign in_range = ({24'd0, req_data.col} < GridWidth) && ({24'd0, req_data.row} < GridHeight);

   // window cell: col offset is win/3-1, row offset win%3-1 (small table)
   always_comb begin
      logic signed [2:0] di;
      logic signed [2:0] dj;
      case (win_ff)
         4'd0: begin di = -3'sd1; dj = -3'sd1; end
         4'd1: begin di = -3'sd1; dj = 3'sd0; end
         4'd2: begin di = -3'sd1; dj = 3'sd1; end
         4'd3: begin di = 3'sd0; dj = -3'sd1; end
         4'd4: begin di = 3'sd0; dj = 3'sd0; end
         4'd5: begin di = 3'sd0; dj = 3'sd1; end
         4'd6: begin di = 3'sd1; dj = -3'sd1; end
         4'd7: begin di = 3'sd1; dj = 3'sd0; end
         default: begin di = 3'sd1; dj = 3'sd1; end
      endcase
      wcol = $signed({2'b00, req_ff.col}) + 10'(di);
      wrow = $signed({2'b00, req_ff.row}) + 10'(dj);
   end
   assign w_off = (wcol < 0) || (wcol >= GridWidth) || (wrow < 0) || (wrow >= GridHeight);

   // neighbor of current center, bit order of the mask
   always_comb begin
      logic signed [2:0] dc;
      logic signed [2:0] dr;
      case (nbr_ff)
         3'd0: begin dc = -3'sd1; dr = -3'sd1; end
         3'd1: begin dc = 3'sd0; dr = -3'sd1; end
         3'd2: begin dc = 3'sd1; dr = -3'sd1; end
         3'd3: begin dc = -3'sd1; dr = 3'sd0; end
         3'd4: begin dc = 3'sd1; dr = 3'sd0; end
         3'd5: begin dc = -3'sd1; dr = 3'sd1; end
         3'd6: begin dc = 3'sd0; dr = 3'sd1; end
         default: begin dc = 3'sd1; dr = 3'sd1; end
      endcase
      ncol = $signed({1'b0, ccol_ff}) + 10'(dc);
      nrow = $signed({1'b0, crow_ff}) + 10'(dr);
   end
   assign n_off = (ncol < 0) || (ncol >= GridWidth) || (nrow < 0) || (nrow >= GridHeight);

   assign lut = tsna_pkg::autotile_table(mask_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsna_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.opcode == tsna_pkg::OP_CLEAR) begin
                  state_in = tsna_pkg::ST_CLEAR;
               end else if (req_data.opcode == tsna_pkg::OP_NONE || !in_range) begin
                  state_in = tsna_pkg::ST_RESPOND;
               end else if (req_data.opcode == tsna_pkg::OP_READ) begin
                  state_in = tsna_pkg::ST_READ_WAIT;
               end else begin
                  state_in = tsna_pkg::ST_WRITE;
               end
            end
         end
         tsna_pkg::ST_CLEAR: begin
            if (clr_ff == CntBits'(Depth - 1)) begin
               state_in = init_ff ? tsna_pkg::ST_IDLE : tsna_pkg::ST_RESPOND;
            end
         end
         tsna_pkg::ST_READ_WAIT: state_in = tsna_pkg::ST_RESPOND;
         tsna_pkg::ST_WRITE: state_in = tsna_pkg::ST_CENTER_REQ;
         tsna_pkg::ST_CENTER_REQ: begin
            if (w_off) begin
               state_in = (win_ff == 4'd8) ? tsna_pkg::ST_RESPOND : tsna_pkg::ST_CENTER_REQ;
            end else begin
               state_in = tsna_pkg::ST_CENTER_WAIT;
            end
         end
         tsna_pkg::ST_CENTER_WAIT: begin
            if (rdata.mat == dirt_material) begin
               state_in = tsna_pkg::ST_NBR_REQ;
            end else begin
               state_in = (win_ff == 4'd8) ? tsna_pkg::ST_RESPOND : tsna_pkg::ST_CENTER_REQ;
            end
         end
         tsna_pkg::ST_NBR_REQ: begin
            if (n_off) begin
               state_in = (nbr_ff == 3'd7) ? tsna_pkg::ST_UPDATE : tsna_pkg::ST_NBR_REQ;
            end else begin
               state_in = tsna_pkg::ST_NBR_WAIT;
            end
         end
         tsna_pkg::ST_NBR_WAIT: begin
            state_in = (nbr_ff == 3'd7) ? tsna_pkg::ST_UPDATE : tsna_pkg::ST_NBR_REQ;
         end
         tsna_pkg::ST_UPDATE: begin
            state_in = (win_ff == 4'd8) ? tsna_pkg::ST_RESPOND : tsna_pkg::ST_CENTER_REQ;
         end
         tsna_pkg::ST_RESPOND: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = tsna_pkg::ST_IDLE;
         end
         default: state_in = tsna_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      // hold input while busy or while a stalled response still waits
      req_stall    = (state_ff != tsna_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
      mem_en       = 1'b0;
      mem_req      = '0;
      ccol_in      = ccol_ff;
      crow_in      = crow_ff;
      win_in       = win_ff;
      nbr_in       = nbr_ff;
      mask_in      = mask_ff;
      ctile_in     = ctile_ff;
      clr_in       = clr_ff;
      clr_busy_in  = clr_busy_ff;
      init_in      = init_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         tsna_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_in = '0;
               rsp_in.status = (req_data.opcode == tsna_pkg::OP_WRITE
                  || req_data.opcode == tsna_pkg::OP_READ) && !in_range;
               clr_in = '0;
               clr_busy_in = (req_data.opcode == tsna_pkg::OP_CLEAR);
               if (req_data.opcode == tsna_pkg::OP_READ && in_range) begin
                  mem_en = 1'b1;
                  mem_req.addr = 16'({8'd0, req_data.row} * GridWidth + {8'd0, req_data.col});
               end
            end
         end
         tsna_pkg::ST_CLEAR: begin
            mem_en = 1'b1;
            mem_req.we = 1'b1;
            mem_req.addr = 16'(clr_ff);
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CntBits'(Depth - 1)) begin
               clr_busy_in = 1'b0;
               init_in = 1'b0;
            end
         end
         tsna_pkg::ST_READ_WAIT: begin
            rsp_in.tile_material   = rdata.mat;
            rsp_in.tile_sprite_col = rdata.scol;
            rsp_in.tile_sprite_row = rdata.srow;
         end
         tsna_pkg::ST_WRITE: begin
            mem_en = 1'b1;
            mem_req.we = 1'b1;
            mem_req.addr = 16'({8'd0, req_ff.row} * GridWidth + {8'd0, req_ff.col});
            mem_req.wdata = {req_ff.material, req_ff.sprite_col, req_ff.sprite_row};
            win_in = 4'd0;
         end
         tsna_pkg::ST_CENTER_REQ: begin
            ccol_in = wcol[8:0];
            crow_in = wrow[8:0];
            if (w_off) begin
               win_in = win_ff + 1'b1;
            end else begin
               mem_en = 1'b1;
               mem_req.addr = 16'(wrow[8:0] * GridWidth + wcol[8:0]);
            end
         end
         tsna_pkg::ST_CENTER_WAIT: begin
            ctile_in = rdata;
            nbr_in = 3'd0;
            mask_in = '0;
            if (rdata.mat != dirt_material) win_in = win_ff + 1'b1;
         end
         tsna_pkg::ST_NBR_REQ: begin
            if (n_off) begin
               mask_in = mask_ff | (8'd1 << nbr_ff);
               nbr_in = nbr_ff + 1'b1;
            end else begin
               mem_en = 1'b1;
               mem_req.addr = 16'(nrow[8:0] * GridWidth + ncol[8:0]);
            end
         end
         tsna_pkg::ST_NBR_WAIT: begin
            if (rdata.mat == dirt_material) mask_in = mask_ff | (8'd1 << nbr_ff);
            nbr_in = nbr_ff + 1'b1;
         end
         tsna_pkg::ST_UPDATE: begin
            mem_en = 1'b1;
            mem_req.we = 1'b1;
            mem_req.addr = 16'(crow_ff * GridWidth + ccol_ff);
            mem_req.wdata = {ctile_ff.mat, lut[15:8], lut[7:0]};
            win_in = win_ff + 1'b1;
         end
         tsna_pkg::ST_RESPOND: begin
            if (!rsp_valid_ff || !rsp_stall) rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   // registers, reset starts the clearing pass over the store
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsna_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_busy_ff  <= 1'b1;
         init_ff      <= 1'b1;
         clr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_busy_ff  <= clr_busy_in;
         init_ff      <= init_in;
         clr_ff       <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      ccol_ff  <= ccol_in;
      crow_ff  <= crow_in;
      win_ff   <= win_in;
      nbr_ff   <= nbr_in;
      mask_ff  <= mask_in;
      ctile_ff <= ctile_in;
      if (state_ff != tsna_pkg::ST_RESPOND) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != tsna_pkg::ST_IDLE) |-> req_stall) else $error("accept while busy");
   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsna_pkg::ST_CLEAR) |-> (mem_en && mem_req.we)) else $error("clear gap");
   a_clr_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsna_pkg::ST_CLEAR) |-> clr_busy_ff) else $error("clear flag");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && $stable(rsp_ff)) else $error("rsp lost");

endmodule

// ===== hdl/tile_store_neighbour_autotile_unit.sv =====
//------------------------------------------------------------------------------
// tile_store_neighbour_autotile_unit
// Tile grid with 8-neighbour bitmask autotiling.
//------------------------------------------------------------------------------
// Usage: one request transfer on req_* gives exactly one response on rsp_*.
// Requests write a tile, read a tile or clear the grid. One item is in work
// at a time; req_stall is high from the accept until the response sits in
// the output register, and stays high while that response is stalled.
// Flow: a read looks up the tile in the store; an out-of-range item or unused
// opcode is answered with no store access; a write stores the tile, then for
// each window cell skips it (off grid), reads it (not dirt) or reads it and up
// to eight neighbours and writes back its sprite (dirt). Clear sweeps the
// single-port tile memory one entry a cycle. A new request can be taken at
// the edge where the previous response is taken.
// Reset: the grid is swept to zero with req_stall high and no response;
// dirt_material returns to 1. A stalled response holds in its register and
// blocks the next request until taken. csr_* writes the dirt material code;
// the user must write it only while idle; the block has no check for this.
//------------------------------------------------------------------------------
module tile_store_neighbour_autotile_unit #(
   parameter int GRID_WIDTH  = tsna_pkg::GridWidthDefault,
   parameter int GRID_HEIGHT = tsna_pkg::GridHeightDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tsna_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tsna_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [3:0]        csr_data
);

   tsna_pkg::mem_req_type mem_req;
   logic                  mem_en;
   tsna_pkg::tile_type    rdata;
   logic [3:0]            dirt_ff;

   // dirt material register
   always_ff @(posedge clock) begin
      if (reset) dirt_ff <= 4'd1;
      else if (csr_write) dirt_ff <= csr_data;
   end

   tsna_seq #(.GridWidth(GRID_WIDTH), .GridHeight(GRID_HEIGHT)) u_seq (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .dirt_material(dirt_ff), .mem_req, .mem_en, .rdata
   );

   tsna_store #(.Depth(GRID_WIDTH * GRID_HEIGHT)) u_store (
      .clock, .mem_req, .mem_en, .rdata
   );

endmodule
